// File: sv/ddo_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ddo_pkg
// Shared types, constants and the CORDIC arctangent table for the odometry.
// ----------------------------------------------------------------------------
package ddo_pkg;

    localparam int CordicSteps = 24;
    localparam int StepW       = $clog2(CordicSteps + 1);
    localparam logic [31:0] CordicStart = 32'h26DD3B6A;

    // register indexes
    localparam logic [1:0] RegLeftScale  = 2'd0;
    localparam logic [1:0] RegRightScale = 2'd1;
    localparam logic [1:0] RegTurnGain   = 2'd2;

    typedef struct packed {
        logic [15:0] left_count;
        logic [15:0] right_count;
    } sample_t;

    typedef struct packed {
        logic signed [31:0] x_position;
        logic signed [31:0] y_position;
        logic [31:0]        heading;
        logic signed [15:0] left_delta;
        logic signed [15:0] right_delta;
        logic               delta_valid;
    } pose_t;

    // controller -> datapath
    typedef struct packed {
        logic load;      // take sample, form deltas
        logic lmul;      // left tick scaling
        logic rmul;      // right tick scaling
        logic turn_mul;  // diff times gain, angle update
        logic rot_init;  // CORDIC start
        logic rot_step;  // one CORDIC iteration
        logic xmul;      // mean times cos
        logic ymul;      // mean times sin
        logic publish;   // result into output register
    } cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic first;
        logic rot_done;
    } stat_t;

    function automatic logic [31:0] atan_lut(input logic [4:0] i);
        logic [31:0] t;
        unique case (i)
            5'd0:  t = 32'h20000000; 5'd1:  t = 32'h12E4051E;
            5'd2:  t = 32'h09FB385B; 5'd3:  t = 32'h051111D4;
            5'd4:  t = 32'h028B0D43; 5'd5:  t = 32'h0145D7E1;
            5'd6:  t = 32'h00A2F61E; 5'd7:  t = 32'h00517C55;
            5'd8:  t = 32'h0028BE53; 5'd9:  t = 32'h00145F2F;
            5'd10: t = 32'h000A2F98; 5'd11: t = 32'h000517CC;
            5'd12: t = 32'h00028BE6; 5'd13: t = 32'h000145F3;
            5'd14: t = 32'h0000A2FA; 5'd15: t = 32'h0000517D;
            5'd16: t = 32'h000028BE; 5'd17: t = 32'h0000145F;
            5'd18: t = 32'h00000A30; 5'd19: t = 32'h00000518;
            5'd20: t = 32'h0000028C; 5'd21: t = 32'h00000146;
            5'd22: t = 32'h000000A3; 5'd23: t = 32'h00000051;
            5'd24: t = 32'h00000029; 5'd25: t = 32'h00000014;
            5'd26: t = 32'h0000000A; 5'd27: t = 32'h00000005;
            5'd28: t = 32'h00000003; 5'd29: t = 32'h00000001;
            5'd30: t = 32'h00000001;
            default: t = 32'h00000000;
        endcase
        return t;
    endfunction

endpackage

// File: sv/ddo_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ddo_ctrl
// Sequencer: steps one sample through scaling, turn, CORDIC and position; a priming sample goes straight to publish.
// ----------------------------------------------------------------------------
module ddo_ctrl
    import ddo_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  in_fire,
    input  logic  out_free,
    input  stat_t stat,
    output logic  busy,
    output cmd_t  cmd
);

    typedef enum logic [8:0] {
        S_IDLE  = 9'b000000001,
        S_LMUL  = 9'b000000010,
        S_RMUL  = 9'b000000100,
        S_TURN  = 9'b000001000,
        S_RINIT = 9'b000010000,
        S_ROT   = 9'b000100000,
        S_XMUL  = 9'b001000000,
        S_YMUL  = 9'b010000000,
        S_PUB   = 9'b100000000
    } state_t;

    state_t state_reg, state_next;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:  if (in_fire) state_next = S_LMUL;
            S_LMUL:  state_next = stat.first ? S_PUB : S_RMUL;
            S_RMUL:  state_next = S_TURN;
            S_TURN:  state_next = S_RINIT;
            S_RINIT: state_next = S_ROT;
            S_ROT:   if (stat.rot_done) state_next = S_XMUL;
            S_XMUL:  state_next = S_YMUL;
            S_YMUL:  state_next = S_PUB;
            S_PUB:   if (out_free) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    assign busy         = (state_reg != S_IDLE);
    assign cmd.load     = in_fire;
    assign cmd.lmul     = (state_reg == S_LMUL) && !stat.first;
    assign cmd.rmul     = (state_reg == S_RMUL);
    assign cmd.turn_mul = (state_reg == S_TURN);
    assign cmd.rot_init = (state_reg == S_RINIT);
    assign cmd.rot_step = (state_reg == S_ROT) && !stat.rot_done;
    assign cmd.xmul     = (state_reg == S_XMUL);
    assign cmd.ymul     = (state_reg == S_YMUL);
    assign cmd.publish  = (state_reg == S_PUB) && out_free;

    // a sample is only taken while idle
    assert property (@(posedge clk) disable iff (!rst_n) in_fire |-> state_reg == S_IDLE)
        else $error("sample taken while busy");
    // publish always returns to idle
    assert property (@(posedge clk) disable iff (!rst_n) cmd.publish |=> state_reg == S_IDLE)
        else $error("publish did not end the item");
    // rotation runs only after the init cycle or itself
    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_ROT |-> $past(state_reg) == S_RINIT || $past(state_reg) == S_ROT)
        else $error("rotation entered out of order");

endmodule

// File: sv/ddo_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ddo_datapath
// Odometry state, a shared multiplier for tick scaling and turn, a position
// multiplier and an iterative CORDIC.
// ----------------------------------------------------------------------------
module ddo_datapath
    import ddo_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  cmd_t        cmd,
    input  sample_t     sample,
    input  logic [31:0] left_scale,
    input  logic [31:0] right_scale,
    input  logic [31:0] turn_gain,
    output stat_t       stat,
    output pose_t       pose
);

    logic [15:0] prev_l_reg, prev_r_reg;
    logic        first_reg;
    logic [31:0] pos_x_reg, pos_y_reg, angle_reg;
    logic [15:0] ld_reg, rd_reg;
    logic        valid_reg;
    logic signed [33:0] lt_reg, rt_reg;    // Q16.16 wheel distances
    logic signed [33:0] x_reg, y_reg;      // CORDIC vector
    logic signed [32:0] z_reg;             // residual angle
    logic               flip_reg;
    logic [StepW-1:0]   step_reg;
    pose_t              pose_reg;

    // wrapped deltas
    logic [15:0] ld_w, rd_w;
    assign ld_w = 16'(16'd0 - (sample.left_count - prev_l_reg));
    assign rd_w = 16'(sample.right_count - prev_r_reg);

    // shared multiplier: one operand signed up to 34 bits, one unsigned 32
    logic signed [33:0] mul_a;
    logic        [31:0] mul_b;
    logic signed [66:0] mul_p;
    logic signed [34:0] sum_lr;
    logic signed [33:0] mean;
    logic signed [33:0] diff;
    logic signed [33:0] trig;

    assign sum_lr = 35'(lt_reg) + 35'(rt_reg);
    assign mean   = 34'(sum_lr >>> 1);
    assign diff   = rt_reg - lt_reg;
    assign trig   = cmd.ymul ? (flip_reg ? -y_reg : y_reg) : (flip_reg ? -x_reg : x_reg);

    always_comb
    begin
        mul_a = diff;
        mul_b = turn_gain;
        priority if (cmd.lmul)
        begin
            mul_a = 34'(signed'(ld_reg));
            mul_b = left_scale;
        end
        else if (cmd.rmul)
        begin
            mul_a = 34'(signed'(rd_reg));
            mul_b = right_scale;
        end
        else
        begin
            mul_a = diff;
            mul_b = turn_gain;
        end
    end

    // trig values span sign: use the signed form for those
    logic signed [66:0] trig_p;
    assign mul_p  = 67'(mul_a) * 67'($signed({1'b0, mul_b}));
    assign trig_p = 67'(mean) * 67'(trig);

    logic signed [66:0] dist_r;
    logic signed [66:0] pos_r;
    assign dist_r = (mul_p + 67'sd32768) >>> 16;
    assign pos_r  = (trig_p + 67'sd536870912) >>> 30;

    // CORDIC step
    logic [4:0] idx;
    logic signed [33:0] xs, ys;
    logic [31:0] new_angle;
    assign idx       = 5'(step_reg);
    assign xs        = x_reg >>> idx;
    assign ys        = y_reg >>> idx;
    assign new_angle = angle_reg - mul_p[31:0];

    // valid_reg holds the priming state of the item in flight
    assign stat.first    = !valid_reg;
    assign stat.rot_done = (step_reg == StepW'(CordicSteps));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_l_reg <= '0;
            prev_r_reg <= '0;
            first_reg  <= 1'b1;
            pos_x_reg  <= '0;
            pos_y_reg  <= '0;
            angle_reg  <= '0;
            valid_reg  <= 1'b0;
            step_reg   <= '0;
        end
        else
        begin
            if (cmd.load)
            begin
                prev_l_reg <= sample.left_count;
                prev_r_reg <= sample.right_count;
                valid_reg  <= !first_reg;
                first_reg  <= 1'b0;
            end
            if (cmd.turn_mul)
                angle_reg <= new_angle;
            if (cmd.rot_init)
                step_reg <= '0;
            else if (cmd.rot_step)
                step_reg <= step_reg + 1'b1;
            if (cmd.xmul)
                pos_x_reg <= pos_x_reg + pos_r[31:0];
            if (cmd.ymul)
                pos_y_reg <= pos_y_reg + pos_r[31:0];
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            ld_reg <= first_reg ? 16'd0 : ld_w;
            rd_reg <= first_reg ? 16'd0 : rd_w;
        end
        if (cmd.lmul)
            lt_reg <= 34'(dist_r);
        if (cmd.rmul)
            rt_reg <= 34'(dist_r);
        if (cmd.rot_init)
        begin
            flip_reg <= angle_reg[31] ^ angle_reg[30];
            x_reg    <= 34'(CordicStart);
            y_reg    <= '0;
            z_reg    <= 33'($signed(angle_reg[31] ^ angle_reg[30] ?
                        angle_reg - 32'h80000000 : angle_reg));
        end
        else if (cmd.rot_step)
        begin
            if (!z_reg[32])
            begin
                x_reg <= x_reg - ys;
                y_reg <= y_reg + xs;
                z_reg <= z_reg - 33'(atan_lut(idx));
            end
            else
            begin
                x_reg <= x_reg + ys;
                y_reg <= y_reg - xs;
                z_reg <= z_reg + 33'(atan_lut(idx));
            end
        end
        if (cmd.publish)
        begin
            pose_reg.x_position  <= pos_x_reg;
            pose_reg.y_position  <= pos_y_reg;
            pose_reg.heading     <= angle_reg;
            pose_reg.left_delta  <= ld_reg;
            pose_reg.right_delta <= rd_reg;
            pose_reg.delta_valid <= valid_reg;
        end
    end

    assign pose = pose_reg;

    // step counter never runs past the iteration count
    assert property (@(posedge clk) disable iff (!rst_n)
        step_reg <= StepW'(CordicSteps))
        else $error("CORDIC step overrun");
    // first flag only clears, and only on a sample
    assert property (@(posedge clk) disable iff (!rst_n)
        $fell(first_reg) |-> $past(cmd.load))
        else $error("first flag cleared without sample");

endmodule

// File: sv/differential_drive_odometry.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// differential_drive_odometry
// Wheel odometry from absolute encoder counts, APB configured.
// ----------------------------------------------------------------------------
// Usage:
//   in channel  : one transfer carries left_count/right_count (sample_t).
//   out channel : one transfer per sample with pose and deltas (pose_t).
//   APB port    : 0x0 left_scale, 0x4 right_scale, 0x8 turn_gain.
// Sequence: the first sample after reset only primes the stored counts and
//   goes from the left-scaling state straight to publish. Later samples run
//   the iterative CORDIC loop, and one shared multiplier is used in turn for
//   the two tick scalings and the heading change; a second multiplier forms
//   the position steps.
// Throughput: one sample at a time; in_ready is high only while idle. The
//   result waits in out_data while out_ready is low; a new sample can be
//   taken then and is computed meanwhile, its result held back until the
//   output register is free.
// Reset: position, heading, stored counts clear, scales return to defaults
//   and the next sample is treated as priming.
// ----------------------------------------------------------------------------
module differential_drive_odometry
    import ddo_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  sample_t     in_data,
    output logic        out_valid,
    input  logic        out_ready,
    output pose_t       out_data,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [31:0] lscale_reg, rscale_reg, gain_reg;
    logic        out_valid_reg;
    logic        busy, in_fire, out_free;
    cmd_t        cmd;
    stat_t       stat;
    logic [1:0]  reg_idx;

    assign reg_idx = paddr[3:2];
    assign pready  = 1'b1;

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lscale_reg <= 32'd4294967;
            rscale_reg <= 32'd4294967;
            gain_reg   <= 32'd52155;
        end
        else if (psel && penable && pwrite)
        begin
            unique case (reg_idx)
                RegLeftScale:  lscale_reg <= pwdata;
                RegRightScale: rscale_reg <= pwdata;
                RegTurnGain:   gain_reg   <= pwdata;
                default: ;
            endcase
        end
    end

    // register readback
    always_comb
    begin
        unique case (reg_idx)
            RegLeftScale:  prdata = lscale_reg;
            RegRightScale: prdata = rscale_reg;
            RegTurnGain:   prdata = gain_reg;
            default:       prdata = '0;
        endcase
    end

    assign in_ready = !busy;
    assign in_fire  = in_valid && in_ready;
    assign out_free = !out_valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.publish)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end
    assign out_valid = out_valid_reg;

    ddo_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_fire  (in_fire),
        .out_free (out_free),
        .stat     (stat),
        .busy     (busy),
        .cmd      (cmd)
    );

    ddo_datapath u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .sample      (in_data),
        .left_scale  (lscale_reg),
        .right_scale (rscale_reg),
        .turn_gain   (gain_reg),
        .stat        (stat),
        .pose        (out_data)
    );

    // a result is only published into a free output register
    assert property (@(posedge clk) disable iff (!rst_n) cmd.publish |-> out_free)
        else $error("output overwritten");

endmodule
